[sv/sm4_pkg.sv]
// sm4_pkg: shared types, constants and functions for the sm4 block cipher
// s-box table, fk constants, ck generation and register indexes
// no dependencies
`timescale 1ns / 1ps

package sm4_pkg;

	localparam int ROUND_COUNT = 32;
	localparam int CNT_W       = $clog2(ROUND_COUNT);
	localparam int WORD_W      = 32;
	localparam int HALF_W      = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = HALF_W;

	typedef logic [WORD_W-1:0]      word_t;
	typedef logic [3:0][WORD_W-1:0] sm4_state_t;
	typedef logic [CNT_W-1:0]       round_idx_t;
	typedef logic [HALF_W-1:0]      half_t;

	// selects which linear transform the round unit applies
	typedef enum logic {
		MIX_KEY,
		MIX_DATA
	} sm4_mix_t;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = CFG_INDEX_W'(1);

	localparam round_idx_t ROUND_LAST = CNT_W'(ROUND_COUNT - 1);

	// system parameter fk, word 0 first
	localparam word_t FK0 = 32'ha3b1bac6;
	localparam word_t FK1 = 32'h56aa3350;
	localparam word_t FK2 = 32'h677d9197;
	localparam word_t FK3 = 32'hb27022dc;

	localparam logic [7:0] SBOX [0:255] = '{
		8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
		8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
		8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
		8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
		8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
		8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
		8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
		8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
		8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
		8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
		8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
		8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
		8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
		8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
		8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
		8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
		8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
		8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
		8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
		8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
		8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
		8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
		8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
		8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
		8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
		8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
		8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
		8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
		8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
		8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
		8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
	};

	// byte-wise s-box over one word
	function automatic word_t subst(input word_t v);
		word_t r;
		r = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
		return r;
	endfunction

	// ck constant: byte j from the top is 7 * (4i + j) mod 256
	function automatic word_t ck_word(input round_idx_t i);
		word_t w;
		logic [7:0] base;
		base = {1'b0, i, 2'b00};
		w[31:24] = 8'(7 * (base + 8'd0));
		w[23:16] = 8'(7 * (base + 8'd1));
		w[15:8]  = 8'(7 * (base + 8'd2));
		w[7:0]   = 8'(7 * (base + 8'd3));
		return w;
	endfunction

endpackage

[sv/sm4_in_if.sv]
// sm4_in_if: input channel carrying one block transfer request
// depends on sm4_pkg
`timescale 1ns / 1ps

interface sm4_in_if;
	import sm4_pkg::*;

	logic  valid;
	logic  ready;
	logic  operation;
	half_t block_high;
	half_t block_low;
	logic  xor_enable;
	half_t mask_high;
	half_t mask_low;

	modport source (
		output valid, operation, block_high, block_low, xor_enable, mask_high, mask_low,
		input  ready
	);

	modport sink (
		input  valid, operation, block_high, block_low, xor_enable, mask_high, mask_low,
		output ready
	);
endinterface

[sv/sm4_out_if.sv]
// sm4_out_if: output channel carrying one result block
// depends on sm4_pkg
`timescale 1ns / 1ps

interface sm4_out_if;
	import sm4_pkg::*;

	logic  valid;
	logic  ready;
	half_t result_high;
	half_t result_low;

	modport source (
		output valid, result_high, result_low,
		input  ready
	);

	modport sink (
		input  valid, result_high, result_low,
		output ready
	);
endinterface

[sv/sm4_round_unit.sv]
// sm4_round_unit: shared round function for key schedule and data rounds
// computes x0 ^ L(S(x1 ^ x2 ^ x3 ^ operand)); depends on sm4_pkg
`timescale 1ns / 1ps

module sm4_round_unit (
	input  sm4_pkg::sm4_state_t w,
	input  sm4_pkg::word_t      operand,
	input  sm4_pkg::sm4_mix_t   mode,
	output sm4_pkg::word_t      nx
);
	import sm4_pkg::*;

	word_t t;
	word_t lin_key;
	word_t lin_data;

	// nonlinear layer
	assign t = subst(w[1] ^ w[2] ^ w[3] ^ operand);

	// key schedule transform: rotations by 13 and 23
	assign lin_key = t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};

	// data transform: rotations by 2, 10, 18 and 24
	assign lin_data = t ^ {t[29:0], t[31:30]} ^ {t[21:0], t[31:22]}
		^ {t[13:0], t[31:14]} ^ {t[7:0], t[31:8]};

	always_comb begin
		unique case (mode)
			MIX_KEY:  nx = w[0] ^ lin_key;
			MIX_DATA: nx = w[0] ^ lin_data;
			default:  nx = w[0] ^ lin_data;
		endcase
	end
endmodule

[sv/sm4_key_store.sv]
// sm4_key_store: generic ram, one write port and one registered read port
// width and depth set by parameters; no dependencies
`timescale 1ns / 1ps

module sm4_key_store #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[sv/sm4_block_cipher_top.sv]
// sm4 block cipher: 32 rounds, one round per cycle on a shared round unit.
// a block is accepted only while idle; no new block is taken until the last result has
// been loaded into the output register, which waits while an unread result is held.
// a key write (and reset) runs a key load and expansion on the same unit,
// during which no input is accepted; reset expands the all-zero key.
// reset: asynchronous, active low; clears the sequencer, key and output valid.
`timescale 1ns / 1ps

module sm4_block_cipher_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [sm4_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [sm4_pkg::CFG_DATA_W-1:0]      cfg_data,
	sm4_in_if.sink                              data_in,
	sm4_out_if.source                           data_out
);
	import sm4_pkg::*;

	typedef enum logic [2:0] {
		S_KEYLOAD,
		S_EXPAND,
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t     state_q;
	round_idx_t cnt_q;
	sm4_state_t w_q;
	half_t      key_high_q;
	half_t      key_low_q;
	logic       op_q;
	logic       xen_q;
	half_t      mask_high_q;
	half_t      mask_low_q;
	logic       out_valid_q;
	half_t      res_high_q;
	half_t      res_low_q;

	logic       go_keyload;
	logic       in_xfer;
	word_t      rk;
	word_t      operand;
	sm4_mix_t   mode;
	word_t      nx;
	round_idx_t rd_cnt;
	logic       rd_op;
	round_idx_t rk_addr;
	sm4_state_t w_shift;
	half_t      fin_high;
	half_t      fin_low;

	// a key write restarts the expansion
	assign go_keyload = cfg_write && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW);

	assign data_in.ready = (state_q == S_IDLE) && !go_keyload;
	assign in_xfer       = data_in.valid && data_in.ready;

	// round key read ahead from the registered store: round 0 while idle, next round while running
	assign rd_cnt  = (state_q == S_RUN) ? round_idx_t'(cnt_q + 1'b1) : '0;
	assign rd_op   = (state_q == S_RUN) ? op_q : data_in.operation;

	// round key order reverses for decryption
	assign rk_addr = rd_op ? round_idx_t'(ROUND_LAST - rd_cnt) : rd_cnt;

	sm4_key_store #(
		.WIDTH (WORD_W),
		.DEPTH (ROUND_COUNT)
	) u_key_store (
		.clk   (clk),
		.we    (state_q == S_EXPAND),
		.waddr (cnt_q),
		.wdata (nx),
		.raddr (rk_addr),
		.rdata (rk)
	);

	// operand select for the shared unit
	assign mode    = (state_q == S_EXPAND) ? MIX_KEY : MIX_DATA;
	assign operand = (state_q == S_EXPAND) ? ck_word(cnt_q) : rk;

	sm4_round_unit u_round (
		.w       (w_q),
		.operand (operand),
		.mode    (mode),
		.nx      (nx)
	);

	assign w_shift = {nx, w_q[3], w_q[2], w_q[1]};

	// reversed words, optional mask
	assign fin_high = {w_q[3], w_q[2]} ^ (xen_q ? mask_high_q : '0);
	assign fin_low  = {w_q[1], w_q[0]} ^ (xen_q ? mask_low_q : '0);

	// sequencer, working state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_KEYLOAD;
			cnt_q       <= '0;
			w_q         <= '0;
			key_high_q  <= '0;
			key_low_q   <= '0;
			op_q        <= 1'b0;
			xen_q       <= 1'b0;
			mask_high_q <= '0;
			mask_low_q  <= '0;
			out_valid_q <= 1'b0;
			res_high_q  <= '0;
			res_low_q   <= '0;
		end else begin
			if (cfg_write && cfg_index == CFG_KEY_HIGH) begin
				key_high_q <= cfg_data;
			end
			if (cfg_write && cfg_index == CFG_KEY_LOW) begin
				key_low_q <= cfg_data;
			end
			// result taken, unless a new one is loaded this cycle
			if (data_out.ready && (go_keyload || state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (go_keyload) begin
				state_q <= S_KEYLOAD;
			end else begin
				unique case (state_q)
					S_KEYLOAD: begin
						w_q[0]  <= key_high_q[63:32] ^ FK0;
						w_q[1]  <= key_high_q[31:0] ^ FK1;
						w_q[2]  <= key_low_q[63:32] ^ FK2;
						w_q[3]  <= key_low_q[31:0] ^ FK3;
						cnt_q   <= '0;
						state_q <= S_EXPAND;
					end
					S_EXPAND: begin
						w_q   <= w_shift;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == ROUND_LAST) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (in_xfer) begin
							w_q[0]      <= data_in.block_high[63:32];
							w_q[1]      <= data_in.block_high[31:0];
							w_q[2]      <= data_in.block_low[63:32];
							w_q[3]      <= data_in.block_low[31:0];
							op_q        <= data_in.operation;
							xen_q       <= data_in.xor_enable;
							mask_high_q <= data_in.mask_high;
							mask_low_q  <= data_in.mask_low;
							cnt_q       <= '0;
							state_q     <= S_RUN;
						end
					end
					S_RUN: begin
						w_q   <= w_shift;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == ROUND_LAST) begin
							state_q <= S_DONE;
						end
					end
					S_DONE: begin
						if (!out_valid_q || data_out.ready) begin
							res_high_q  <= fin_high;
							res_low_q   <= fin_low;
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_KEYLOAD;
					end
				endcase
			end
		end
	end

	assign data_out.valid       = out_valid_q;
	assign data_out.result_high = res_high_q;
	assign data_out.result_low  = res_low_q;
endmodule

[test/tb_top.sv]
// tb_top: self-checking testbench for sm4_block_cipher_top, directed table then random blocks
// depends on sm4_pkg, sm4_in_if, sm4_out_if and the block under test
`timescale 1ns / 1ps

module tb_top;
	import sm4_pkg::*;

	localparam int DRAIN_CYCLES   = 40;
	localparam int RAND_PHASES    = 7;
	localparam int RAND_PER_PHASE = 200;
	localparam int TIMEOUT_NS     = 10_000_000;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// indexes beyond the key registers, writes to them are dropped
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE2 = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE3 = CFG_INDEX_W'(3);

	localparam half_t ZERO  = '0;
	localparam half_t ONES  = '1;
	localparam half_t ALT_A = 64'haaaaaaaaaaaaaaaa;
	localparam half_t ALT_5 = 64'h5555555555555555;

	// standard sm4 vector: key equals plaintext
	localparam half_t STD_KEY_HI = 64'h0123456789abcdef;
	localparam half_t STD_KEY_LO = 64'hfedcba9876543210;
	localparam half_t STD_CT_HI  = 64'h681edf34d206965e;
	localparam half_t STD_CT_LO  = 64'h86b3e94f536e4246;

	typedef struct packed {
		logic  op;
		half_t block_high;
		half_t block_low;
		logic  xor_enable;
		half_t mask_high;
		half_t mask_low;
	} blk_req_t;

	typedef struct packed {
		half_t result_high;
		half_t result_low;
	} cipher_out_t;

	typedef enum logic {
		ROW_BLOCK,
		ROW_KEY
	} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [CFG_INDEX_W-1:0]   reg_idx;
		half_t                    reg_data;
		blk_req_t                 req;
		logic                     has_known;
		half_t                    known_high;
		half_t                    known_low;
	} dir_row_t;

	localparam blk_req_t NO_REQ = '0;
	localparam int DIR_ROWS = 26;

	// directed rows: key writes and blocks, known results only where obvious
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// all-zero key from reset
		'{ROW_BLOCK, '0, ZERO, '{OP_ENCRYPT, ZERO, ZERO, 1'b0, ZERO, ZERO}, 1'b0, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_ENCRYPT, ONES, ONES, 1'b1, ONES, ONES}, 1'b0, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_DECRYPT, ONES, ONES, 1'b0, ALT_A, ALT_5}, 1'b0, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_DECRYPT, ZERO, ZERO, 1'b1, ALT_A, ALT_5}, 1'b0, ZERO, ZERO},
		// standard key
		'{ROW_KEY, CFG_KEY_HIGH, STD_KEY_HI, NO_REQ, 1'b0, ZERO, ZERO},
		'{ROW_KEY, CFG_KEY_LOW, STD_KEY_LO, NO_REQ, 1'b0, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_ENCRYPT, STD_KEY_HI, STD_KEY_LO, 1'b0, ZERO, ZERO},
			1'b1, STD_CT_HI, STD_CT_LO},
		'{ROW_BLOCK, '0, ZERO, '{OP_DECRYPT, STD_CT_HI, STD_CT_LO, 1'b0, ZERO, ZERO},
			1'b1, STD_KEY_HI, STD_KEY_LO},
		'{ROW_BLOCK, '0, ZERO, '{OP_ENCRYPT, STD_KEY_HI, STD_KEY_LO, 1'b1, STD_CT_HI, STD_CT_LO},
			1'b1, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_ENCRYPT, STD_KEY_HI, STD_KEY_LO, 1'b0, ONES, ONES},
			1'b1, STD_CT_HI, STD_CT_LO},
		'{ROW_BLOCK, '0, ZERO, '{OP_DECRYPT, STD_CT_HI, STD_CT_LO, 1'b1, STD_KEY_HI, STD_KEY_LO},
			1'b1, ZERO, ZERO},
		// writes past the key registers leave the key alone
		'{ROW_KEY, CFG_SPARE2, ONES, NO_REQ, 1'b0, ZERO, ZERO},
		'{ROW_KEY, CFG_SPARE3, ALT_5, NO_REQ, 1'b0, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_ENCRYPT, STD_KEY_HI, STD_KEY_LO, 1'b0, ZERO, ZERO},
			1'b1, STD_CT_HI, STD_CT_LO},
		// one half rewritten, key mixes new and old halves
		'{ROW_KEY, CFG_KEY_HIGH, ONES, NO_REQ, 1'b0, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_ENCRYPT, ZERO, ZERO, 1'b0, ZERO, ZERO}, 1'b0, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_DECRYPT, ONES, ONES, 1'b1, ALT_5, ALT_A}, 1'b0, ZERO, ZERO},
		// all-ones key
		'{ROW_KEY, CFG_KEY_LOW, ONES, NO_REQ, 1'b0, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_ENCRYPT, ZERO, ZERO, 1'b0, ZERO, ZERO}, 1'b0, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_ENCRYPT, ONES, ONES, 1'b1, ZERO, ZERO}, 1'b0, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_DECRYPT, 64'h8000000000000001, 64'h0000000180000000,
			1'b0, ZERO, ZERO}, 1'b0, ZERO, ZERO},
		// back to the all-zero key
		'{ROW_KEY, CFG_KEY_HIGH, ZERO, NO_REQ, 1'b0, ZERO, ZERO},
		'{ROW_KEY, CFG_KEY_LOW, ZERO, NO_REQ, 1'b0, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_ENCRYPT, STD_KEY_HI, STD_KEY_LO, 1'b0, ZERO, ZERO},
			1'b0, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_DECRYPT, ZERO, ZERO, 1'b0, ZERO, ZERO}, 1'b0, ZERO, ZERO},
		'{ROW_BLOCK, '0, ZERO, '{OP_ENCRYPT, ALT_A, ALT_5, 1'b1, ALT_5, ALT_A}, 1'b0, ZERO, ZERO}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	sm4_in_if  data_in_if ();
	sm4_out_if data_out_if ();

	sm4_block_cipher_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.data_in  (data_in_if),
		.data_out (data_out_if)
	);

	// predictor state: key registers and expanded round keys
	half_t       key_hi_q;
	half_t       key_lo_q;
	word_t       rk_table [ROUND_COUNT];
	cipher_out_t pending_blocks [$];
	bit          steady;
	int          errors;

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// byte-wise substitution
	function automatic word_t sbox_word(input word_t v);
		return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	function automatic word_t rol(input word_t v, input int n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	function automatic word_t key_lin(input word_t t);
		return t ^ rol(t, 13) ^ rol(t, 23);
	endfunction

	function automatic word_t data_lin(input word_t t);
		return t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
	endfunction

	// schedule constant, byte j from the top is 7 * (4i + j)
	function automatic word_t ck_const(input int i);
		word_t w;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			w = {w[23:0], 8'(7 * (4 * i + j))};
		end
		return w;
	endfunction

	// expand the current key registers into the round key table
	function automatic void rebuild_round_keys();
		word_t k [4];
		word_t nk;
		k[0] = key_hi_q[63:32] ^ FK0;
		k[1] = key_hi_q[31:0] ^ FK1;
		k[2] = key_lo_q[63:32] ^ FK2;
		k[3] = key_lo_q[31:0] ^ FK3;
		for (int i = 0; i < ROUND_COUNT; i++) begin
			nk = k[0] ^ key_lin(sbox_word(k[1] ^ k[2] ^ k[3] ^ ck_const(i)));
			rk_table[i] = nk;
			k[0] = k[1];
			k[1] = k[2];
			k[2] = k[3];
			k[3] = nk;
		end
	endfunction

	// 32 rounds, reversed word order, optional mask
	function automatic cipher_out_t cipher_block(input blk_req_t req);
		word_t       x [4];
		word_t       rk;
		word_t       nx;
		cipher_out_t r;
		x[0] = req.block_high[63:32];
		x[1] = req.block_high[31:0];
		x[2] = req.block_low[63:32];
		x[3] = req.block_low[31:0];
		for (int i = 0; i < ROUND_COUNT; i++) begin
			rk = (req.op == OP_DECRYPT) ? rk_table[ROUND_COUNT - 1 - i] : rk_table[i];
			nx = x[0] ^ data_lin(sbox_word(x[1] ^ x[2] ^ x[3] ^ rk));
			x[0] = x[1];
			x[1] = x[2];
			x[2] = x[3];
			x[3] = nx;
		end
		r.result_high = {x[3], x[2]};
		r.result_low  = {x[1], x[0]};
		if (req.xor_enable) begin
			r.result_high ^= req.mask_high;
			r.result_low  ^= req.mask_low;
		end
		return r;
	endfunction

	// random half with extra weight on all-zero and all-ones
	function automatic half_t rand_half();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return ZERO;
		if (pick == 1) return ONES;
		return {$urandom, $urandom};
	endfunction

	function automatic blk_req_t rand_req();
		blk_req_t r;
		r.op         = 1'($urandom_range(0, 1));
		r.block_high = rand_half();
		r.block_low  = rand_half();
		r.xor_enable = 1'($urandom_range(0, 1));
		r.mask_high  = rand_half();
		r.mask_low   = rand_half();
		return r;
	endfunction

	// one input transfer; entered and left at a rising edge
	task automatic send_block(input blk_req_t req, input logic has_known,
		input cipher_out_t known);
		int gap;
		gap = 0;
		while (!steady && $urandom_range(0, 99) < 31) gap++;
		if (gap > 0) begin
			data_in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_in_if.operation  <= req.op;
		data_in_if.block_high <= req.block_high;
		data_in_if.block_low  <= req.block_low;
		data_in_if.xor_enable <= req.xor_enable;
		data_in_if.mask_high  <= req.mask_high;
		data_in_if.mask_low   <= req.mask_low;
		data_in_if.valid      <= 1'b1;
		do @(posedge clk); while (!(data_in_if.valid && data_in_if.ready));
		if (has_known) pending_blocks.push_back(known);
		else pending_blocks.push_back(cipher_block(req));
	endtask

	// register write once the block has drained and finished any expansion
	task automatic write_key_reg(input logic [CFG_INDEX_W-1:0] idx, input half_t val);
		data_in_if.valid <= 1'b0;
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_KEY_HIGH: key_hi_q = val;
			CFG_KEY_LOW:  key_lo_q = val;
			default: ;
		endcase
		rebuild_round_keys();
	endtask

	// result check and receiver stalls
	always @(posedge clk) begin : result_check
		cipher_out_t want;
		if (data_out_if.valid && data_out_if.ready) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t: result with no block pending: actual %h %h", $time,
					data_out_if.result_high, data_out_if.result_low);
				errors++;
			end else begin
				want = pending_blocks.pop_front();
				if (data_out_if.result_high !== want.result_high) begin
					$display("%0t: result_high mismatch: expected %h, actual %h", $time,
						want.result_high, data_out_if.result_high);
					errors++;
				end
				if (data_out_if.result_low !== want.result_low) begin
					$display("%0t: result_low mismatch: expected %h, actual %h", $time,
						want.result_low, data_out_if.result_low);
					errors++;
				end
			end
		end
		data_out_if.ready <= steady || ($urandom_range(0, 99) >= 31);
	end

	// stimulus
	initial begin : stimulus
		cipher_out_t known;
		arst_n                = 1'b0;
		cfg_write             = 1'b0;
		cfg_index             = '0;
		cfg_data              = '0;
		data_in_if.valid      = 1'b0;
		data_in_if.operation  = OP_ENCRYPT;
		data_in_if.block_high = '0;
		data_in_if.block_low  = '0;
		data_in_if.xor_enable = 1'b0;
		data_in_if.mask_high  = '0;
		data_in_if.mask_low   = '0;
		data_out_if.ready     = 1'b0;
		steady                = 1'b0;
		errors                = 0;
		key_hi_q              = '0;
		key_lo_q              = '0;
		rebuild_round_keys();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int n = 0; n < DIR_ROWS; n++) begin
			if (DIR_TABLE[n].kind == ROW_KEY) begin
				write_key_reg(DIR_TABLE[n].reg_idx, DIR_TABLE[n].reg_data);
			end else begin
				known.result_high = DIR_TABLE[n].known_high;
				known.result_low  = DIR_TABLE[n].known_low;
				send_block(DIR_TABLE[n].req, DIR_TABLE[n].has_known, known);
			end
		end

		// random phases, each under its own key setting
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			steady = (ph == 2);
			case (ph)
				1: begin
					write_key_reg(CFG_KEY_HIGH, ONES);
					write_key_reg(CFG_KEY_LOW, ONES);
				end
				2: write_key_reg(CFG_KEY_HIGH, {$urandom, $urandom});
				3: begin
					write_key_reg(CFG_SPARE2, {$urandom, $urandom});
					write_key_reg(CFG_KEY_LOW, {$urandom, $urandom});
				end
				4: begin
					write_key_reg(CFG_KEY_HIGH, ZERO);
					write_key_reg(CFG_KEY_LOW, ZERO);
				end
				default: begin
					write_key_reg(CFG_KEY_HIGH, {$urandom, $urandom});
					write_key_reg(CFG_KEY_LOW, {$urandom, $urandom});
				end
			endcase
			known = '0;
			repeat (RAND_PER_PHASE) send_block(rand_req(), 1'b0, known);
		end
		steady = 1'b0;

		// drain
		data_in_if.valid <= 1'b0;
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
